/* hdl/ppusar_pkg.sv */
`default_nettype none

package ppusar_pkg;

   localparam int ADDR_WIDTH  = 15;
   localparam int FETCH_WIDTH = 14;

   localparam logic [3:0] CMD_CTRL    = 4'd0;
   localparam logic [3:0] CMD_MASK    = 4'd1;
   localparam logic [3:0] CMD_SCROLL  = 4'd2;
   localparam logic [3:0] CMD_ADDR    = 4'd3;
   localparam logic [3:0] CMD_DATA    = 4'd4;
   localparam logic [3:0] CMD_INCX    = 4'd5;
   localparam logic [3:0] CMD_INCY    = 4'd6;
   localparam logic [3:0] CMD_COPYX   = 4'd7;
   localparam logic [3:0] CMD_COPYY   = 4'd8;
   localparam logic [3:0] CMD_VBL_ON  = 4'd9;
   localparam logic [3:0] CMD_VBL_OFF = 4'd10;

   localparam logic [ADDR_WIDTH-1:0]  COARSE_X_WRAP = 15'h041F;
   localparam logic [ADDR_WIDTH-1:0]  HORIZ_MASK    = 15'h041F;
   localparam logic [ADDR_WIDTH-1:0]  VERT_MASK     = 15'h7BE0;
   localparam logic [ADDR_WIDTH-1:0]  FINE_Y_STEP   = 15'h1000;
   localparam logic [ADDR_WIDTH-1:0]  STEP_WIDE     = 15'd32;
   localparam logic [ADDR_WIDTH-1:0]  STEP_NARROW   = 15'd1;
   localparam logic [FETCH_WIDTH-1:0] NT_BASE       = 14'h2000;
   localparam logic [FETCH_WIDTH-1:0] ATTR_BASE     = 14'h23C0;

   typedef struct packed {
      logic [3:0] cmd;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]  vram_address;
      logic [2:0]             fine_scroll_x;
      logic                   vram_write_strobe;
      logic [ADDR_WIDTH-1:0]  vram_write_address;
      logic [7:0]             vram_write_data;
      logic [FETCH_WIDTH-1:0] nametable_fetch_address;
      logic [FETCH_WIDTH-1:0] attribute_fetch_address;
      logic                   nmi_pulse;
      logic                   vblank_flag;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/ppusar_req_stage.sv */
`default_nettype none

module ppusar_req_stage (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  ppusar_pkg::req_type      req_payload,
   input  wire                      advance,
   output logic                     stage_valid,
   output ppusar_pkg::req_type      stage_payload
);
   import ppusar_pkg::*;

   logic    valid_ff, valid_in;
   req_type payload_ff, payload_in;
   logic    accept;

   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (accept) begin
         valid_in   = 1'b1;
         payload_in = req_payload;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign stage_valid   = valid_ff;
   assign stage_payload = payload_ff;

endmodule

`default_nettype wire

/* hdl/ppusar_core.sv */
`default_nettype none

module ppusar_core (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,
   input  ppusar_pkg::req_type      stage_payload,
   output ppusar_pkg::rsp_type      result
);
   import ppusar_pkg::*;

   logic [ADDR_WIDTH-1:0] temp_ff, temp_in;
   logic [ADDR_WIDTH-1:0] cur_ff, cur_in;
   logic [2:0]            fine_x_ff, fine_x_in;
   logic                  toggle_ff, toggle_in;
   logic [7:0]            ctrl_ff, ctrl_in;
   logic [7:0]            mask_ff, mask_in;
   logic                  vblank_ff, vblank_in;

   logic                  rendering;
   logic [4:0]            cy;
   logic [4:0]            cy_next;
   logic                  nt_flip;
   logic [7:0]            val;

   assign rendering = mask_ff[3] || mask_ff[4];
   assign val       = stage_payload.value;
   assign cy        = cur_ff[9:5];

   always_comb begin
      cy_next = cy + 5'd1;
      nt_flip = 1'b0;
      if (cy == 5'd31) begin
         cy_next = 5'd0;
      end else if (cy == 5'd29) begin
         cy_next = 5'd0;
         nt_flip = 1'b1;
      end
   end

   always_comb begin
      temp_in   = temp_ff;
      cur_in    = cur_ff;
      fine_x_in = fine_x_ff;
      toggle_in = toggle_ff;
      ctrl_in   = ctrl_ff;
      mask_in   = mask_ff;
      vblank_in = vblank_ff;
      result    = '0;
      unique case (stage_payload.cmd)
         CMD_CTRL: begin
            ctrl_in        = val;
            temp_in[11:10] = val[1:0];
         end
         CMD_MASK: begin
            mask_in = val;
         end
         CMD_SCROLL: begin
            if (!toggle_ff) begin
               temp_in[4:0] = val[7:3];
               fine_x_in    = val[2:0];
               toggle_in    = 1'b1;
            end else begin
               temp_in[9:5]   = val[7:3];
               temp_in[14:12] = val[2:0];
               toggle_in      = 1'b0;
            end
         end
         CMD_ADDR: begin
            if (!toggle_ff) begin
               temp_in   = {1'b0, val[5:0], temp_ff[7:0]};
               toggle_in = 1'b1;
            end else begin
               temp_in   = {temp_ff[14:8], val};
               cur_in    = {temp_ff[14:8], val};
               toggle_in = 1'b0;
            end
         end
         CMD_DATA: begin
            result.vram_write_strobe  = 1'b1;
            result.vram_write_address = cur_ff;
            result.vram_write_data    = val;
            cur_in = cur_ff + (ctrl_ff[2] ? STEP_WIDE : STEP_NARROW);
         end
         CMD_INCX: begin
            if (rendering) begin
               if (cur_ff[4:0] == 5'd31) begin
                  cur_in = cur_ff ^ COARSE_X_WRAP;
               end else begin
                  cur_in = cur_ff + STEP_NARROW;
               end
            end
         end
         CMD_INCY: begin
            if (rendering) begin
               if (cur_ff[14:12] != 3'd7) begin
                  cur_in = cur_ff + FINE_Y_STEP;
               end else begin
                  cur_in = {3'b000, cur_ff[11] ^ nt_flip, cur_ff[10], cy_next, cur_ff[4:0]};
               end
            end
         end
         CMD_COPYX: begin
            if (rendering) begin
               cur_in = (cur_ff & ~HORIZ_MASK) | (temp_ff & HORIZ_MASK);
            end
         end
         CMD_COPYY: begin
            if (rendering) begin
               cur_in = (cur_ff & ~VERT_MASK) | (temp_ff & VERT_MASK);
            end
         end
         CMD_VBL_ON: begin
            vblank_in        = 1'b1;
            result.nmi_pulse = ctrl_ff[7];
         end
         CMD_VBL_OFF: begin
            vblank_in = 1'b0;
         end
         default: begin
         end
      endcase
      result.vram_address            = cur_in;
      result.fine_scroll_x           = fine_x_in;
      result.vblank_flag             = vblank_in;
      result.nametable_fetch_address = NT_BASE | {2'b00, cur_in[11:0]};
      result.attribute_fetch_address = ATTR_BASE
         | {2'b00, cur_in[11:10], 4'b0000, cur_in[9:7], cur_in[4:2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff   <= '0;
         cur_ff    <= '0;
         fine_x_ff <= '0;
         toggle_ff <= 1'b0;
         ctrl_ff   <= '0;
         mask_ff   <= '0;
         vblank_ff <= 1'b0;
      end else if (advance) begin
         temp_ff   <= temp_in;
         cur_ff    <= cur_in;
         fine_x_ff <= fine_x_in;
         toggle_ff <= toggle_in;
         ctrl_ff   <= ctrl_in;
         mask_ff   <= mask_in;
         vblank_ff <= vblank_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ppusar_rsp_stage.sv */
`default_nettype none

module ppusar_rsp_stage (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,
   input  ppusar_pkg::rsp_type      result,
   output logic                     load_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output ppusar_pkg::rsp_type      rsp_payload
);
   import ppusar_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type payload_ff, payload_in;

   assign load_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (advance) begin
         valid_in   = 1'b1;
         payload_in = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      payload_ff <= payload_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

`default_nettype wire

/* hdl/ppu_scroll_address_registers_top.sv */
// Path: an accepted transaction is held in the input register, passes the
// combinational core and is held in the result register, which drives rsp_.
// Throughput: one transaction per cycle while rsp_ready is high; the input and
// result registers each hold one, so one more is taken while a result stalls.
// Reset: synchronous, active high; clears all scroll and address state and
// both valid flags.
`default_nettype none

module ppu_scroll_address_registers_top (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  ppusar_pkg::req_type      req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output ppusar_pkg::rsp_type      rsp_payload
);
   import ppusar_pkg::*;

   logic    stage_valid;
   req_type stage_payload;
   rsp_type result;
   logic    load_ready;
   logic    advance;

   assign advance = stage_valid && load_ready;

   ppusar_req_stage u_req_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .advance       (advance),
      .stage_valid   (stage_valid),
      .stage_payload (stage_payload)
   );

   ppusar_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .stage_payload (stage_payload),
      .result        (result)
   );

   ppusar_rsp_stage u_rsp_stage (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .result      (result),
      .load_ready  (load_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* hdl/ppusar_checker.sv */
`default_nettype none

module ppusar_checker (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      rsp_valid,
   input  wire                      rsp_ready,
   input  ppusar_pkg::rsp_type      rsp_payload
);
   import ppusar_pkg::*;

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.vram_write_strobe
         |-> rsp_payload.vram_write_address == '0 && rsp_payload.vram_write_data == '0)
      else $error("write fields set without strobe");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.nametable_fetch_address
         == (NT_BASE | {2'b00, rsp_payload.vram_address[11:0]}))
      else $error("nametable fetch address mismatch");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.nmi_pulse |-> rsp_payload.vblank_flag)
      else $error("nmi without vblank");

endmodule

bind ppu_scroll_address_registers_top ppusar_checker u_checker (.*);

`default_nettype wire

/* sim/ppu_scroll_address_registers_checker.sv */
`default_nettype none

module ppu_scroll_address_registers_checker
   import ppusar_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_ready,
   input  req_type req_payload,
   input  wire     rsp_valid,
   input  wire     rsp_ready,
   input  rsp_type rsp_payload,
   output int      mismatch_count,
   output int      pending_count
);

   logic [ADDR_WIDTH-1:0] temp_addr;
   logic [ADDR_WIDTH-1:0] cur_addr;
   logic [2:0]            fine_x;
   logic                  toggle;
   logic [7:0]            ctrl_byte;
   logic [7:0]            mask_byte;
   logic                  vblank;
   rsp_type               expected_views[$];

   task automatic apply_command(input req_type t, output rsp_type r);
      logic [4:0] cy;
      logic [7:0] v;
      logic       render;
      r      = '0;
      v      = t.value;
      render = mask_byte[4:3] != 2'b00;
      case (t.cmd)
         CMD_CTRL: begin
            ctrl_byte         = v;
            temp_addr[11:10]  = v[1:0];
         end
         CMD_MASK: mask_byte = v;
         CMD_SCROLL: begin
            if (!toggle) begin
               temp_addr[4:0] = v[7:3];
               fine_x         = v[2:0];
               toggle         = 1'b1;
            end else begin
               temp_addr[9:5]   = v[7:3];
               temp_addr[14:12] = v[2:0];
               toggle           = 1'b0;
            end
         end
         CMD_ADDR: begin
            if (!toggle) begin
               temp_addr[14:8] = {1'b0, v[5:0]};
               toggle          = 1'b1;
            end else begin
               temp_addr[7:0] = v;
               cur_addr       = temp_addr;
               toggle         = 1'b0;
            end
         end
         CMD_DATA: begin
            r.vram_write_strobe  = 1'b1;
            r.vram_write_address = cur_addr;
            r.vram_write_data    = v;
            cur_addr = cur_addr + (ctrl_byte[2] ? STEP_WIDE : STEP_NARROW);
         end
         CMD_INCX: begin
            if (render) begin
               if (cur_addr[4:0] == 5'd31) cur_addr = cur_addr ^ COARSE_X_WRAP;
               else cur_addr = cur_addr + 15'd1;
            end
         end
         CMD_INCY: begin
            if (render) begin
               if (cur_addr[14:12] != 3'd7) begin
                  cur_addr = cur_addr + FINE_Y_STEP;
               end else begin
                  cur_addr[14:12] = 3'd0;
                  cy = cur_addr[9:5];
                  if (cy == 5'd31) begin
                     cy = 5'd0;
                  end else if (cy == 5'd29) begin
                     cy           = 5'd0;
                     cur_addr[11] = ~cur_addr[11];
                  end else begin
                     cy = cy + 5'd1;
                  end
                  cur_addr[9:5] = cy;
               end
            end
         end
         CMD_COPYX: begin
            if (render) cur_addr = (cur_addr & ~HORIZ_MASK) | (temp_addr & HORIZ_MASK);
         end
         CMD_COPYY: begin
            if (render) cur_addr = (cur_addr & ~VERT_MASK) | (temp_addr & VERT_MASK);
         end
         CMD_VBL_ON: begin
            vblank      = 1'b1;
            r.nmi_pulse = ctrl_byte[7];
         end
         CMD_VBL_OFF: vblank = 1'b0;
         default: ;
      endcase
      r.vram_address            = cur_addr;
      r.fine_scroll_x           = fine_x;
      r.nametable_fetch_address = NT_BASE | {2'b00, cur_addr[11:0]};
      r.attribute_fetch_address = ATTR_BASE
         | {2'b00, cur_addr[11:10], 4'b0000, cur_addr[9:7], cur_addr[4:2]};
      r.vblank_flag             = vblank;
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      if (reset) begin
         temp_addr = '0;
         cur_addr  = '0;
         fine_x    = '0;
         toggle    = 1'b0;
         ctrl_byte = '0;
         mask_byte = '0;
         vblank    = 1'b0;
         expected_views.delete();
      end else begin
         if (req_valid && req_ready) begin
            apply_command(req_payload, predicted);
            expected_views.insert(expected_views.size(), predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               $error("result transaction with no command pending");
               mismatch_count++;
            end else begin
               oldest = expected_views.pop_front();
               check_field("vram_address", oldest.vram_address, rsp_payload.vram_address);
               check_field("fine_scroll_x", oldest.fine_scroll_x,
                           rsp_payload.fine_scroll_x);
               check_field("vram_write_strobe", oldest.vram_write_strobe,
                           rsp_payload.vram_write_strobe);
               check_field("vram_write_address", oldest.vram_write_address,
                           rsp_payload.vram_write_address);
               check_field("vram_write_data", oldest.vram_write_data,
                           rsp_payload.vram_write_data);
               check_field("nametable_fetch_address", oldest.nametable_fetch_address,
                           rsp_payload.nametable_fetch_address);
               check_field("attribute_fetch_address", oldest.attribute_fetch_address,
                           rsp_payload.attribute_fetch_address);
               check_field("nmi_pulse", oldest.nmi_pulse, rsp_payload.nmi_pulse);
               check_field("vblank_flag", oldest.vblank_flag, rsp_payload.vblank_flag);
            end
         end
      end
      pending_count = expected_views.size();
   end

endmodule

`default_nettype wire

/* sim/tb_ppu_scroll_address_registers_top.sv */
`default_nettype none

module tb_ppu_scroll_address_registers_top;
   import ppusar_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   int      mismatch_count;
   int      pending_count;
   bit      idle_on;
   int      stall_requests;

   ppu_scroll_address_registers_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   ppu_scroll_address_registers_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_command(input logic [3:0] cmd, input logic [7:0] value);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_payload = '{cmd: cmd, value: value};
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pick_random_command(output logic [3:0] cmd, output logic [7:0] value);
      int unsigned roll;
      roll  = $urandom_range(0, 99);
      value = 8'($urandom_range(0, 255));
      if (roll < 8) cmd = CMD_CTRL;
      else if (roll < 16) begin
         cmd = CMD_MASK;
         if ($urandom_range(0, 3) != 0) value[3 + $urandom_range(0, 1)] = 1'b1;
      end
      else if (roll < 28) cmd = CMD_SCROLL;
      else if (roll < 40) cmd = CMD_ADDR;
      else if (roll < 55) cmd = CMD_DATA;
      else if (roll < 65) cmd = CMD_INCX;
      else if (roll < 75) cmd = CMD_INCY;
      else if (roll < 82) cmd = CMD_COPYX;
      else if (roll < 88) cmd = CMD_COPYY;
      else if (roll < 93) cmd = CMD_VBL_ON;
      else if (roll < 98) cmd = CMD_VBL_OFF;
      else cmd = 4'($urandom_range(11, 15));
   endtask

   initial begin
      int         served;
      int         n;
      served    = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_requests != served) begin
            served    = stall_requests;
            rsp_ready = 1'b0;
            for (n = 0; n < 60; n++) @(negedge clock);
            rsp_ready = 1'b1;
         end else if (!reset && idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = !reset;
         end
      end
   end

   initial begin
      int         idx;
      logic [3:0] cmd;
      logic [7:0] value;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      idle_on        = 1'b1;
      stall_requests = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_command(CMD_CTRL, 8'h83);
      send_command(CMD_MASK, 8'h08);
      send_command(CMD_SCROLL, 8'hFF);
      send_command(CMD_SCROLL, 8'hFF);
      send_command(CMD_COPYY, 8'h00);
      send_command(CMD_COPYX, 8'h00);
      send_command(CMD_DATA, 8'hA5);
      send_command(CMD_COPYY, 8'hFF);
      send_command(CMD_COPYX, 8'hFF);
      send_command(CMD_INCX, 8'h00);
      send_command(CMD_INCY, 8'h00);
      send_command(CMD_VBL_ON, 8'h00);
      send_command(CMD_CTRL, 8'h04);
      send_command(CMD_ADDR, 8'hFF);
      send_command(CMD_ADDR, 8'hFF);
      send_command(CMD_DATA, 8'h00);
      send_command(CMD_VBL_ON, 8'hFF);
      send_command(CMD_VBL_OFF, 8'h00);
      send_command(CMD_MASK, 8'h10);
      send_command(CMD_SCROLL, 8'h00);
      send_command(CMD_SCROLL, 8'hEF);
      send_command(CMD_COPYY, 8'h00);
      send_command(CMD_INCY, 8'h00);
      send_command(CMD_MASK, 8'h00);
      send_command(CMD_INCX, 8'h00);
      send_command(CMD_INCY, 8'h00);
      send_command(CMD_COPYX, 8'h00);
      send_command(CMD_COPYY, 8'h00);
      send_command(4'd11, 8'h5A);
      send_command(4'd15, 8'hFF);

      for (idx = 0; idx < 800; idx++) begin
         idle_on = (idx < 700) && ((idx / 50) % 4 != 3);
         if (idx == 200) stall_requests = stall_requests + 1;
         if (idx == 400) begin
            @(negedge clock);
            req_valid = 1'b0;
            wait (pending_count == 0);
         end
         pick_random_command(cmd, value);
         send_command(cmd, value);
      end
      @(negedge clock);
      req_valid = 1'b0;

      wait (pending_count == 0);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
